// ----- hw/rtl/ava_pkg.sv -----
// ----------------------------------------------------------------------------
// ava_pkg
// Shared constants, types and register codes of the averaged voltage
// autorange unit.
// ----------------------------------------------------------------------------
package ava_pkg;

  localparam int DEF_WINDOW_DEPTH = 256;
  localparam int DEF_SAMPLE_BITS  = 10;
  localparam int DIV_LAT          = 2;

  localparam int FACTOR_W  = 16;
  localparam int VOLT_W    = 26;
  localparam int AVG_W     = 10;
  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 2;

  localparam logic [FACTOR_W-1:0] RST_LOW_FACTOR  = 16'd975;
  localparam logic [FACTOR_W-1:0] RST_HIGH_FACTOR = 16'd4882;
  localparam logic [VOLT_W-1:0]   RST_UP_THR      = 26'd3000000;
  localparam logic [VOLT_W-1:0]   RST_DOWN_THR    = 26'd2500000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_FACTOR  = 2'd0,
    CFG_HIGH_FACTOR = 2'd1,
    CFG_UP_THR      = 2'd2,
    CFG_DOWN_THR    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              range_next_low;
    logic              range_used_low;
    logic [AVG_W-1:0]  average_raw;
    logic [VOLT_W-1:0] voltage_uv;
  } result_t;

endpackage

// ----- hw/rtl/ava_cdiv.sv -----
// ----------------------------------------------------------------------------
// ava_cdiv
// Division by a constant divisor through multiplication with a rounded-up
// reciprocal, exact for every dividend of XW bits. The product is built from
// four partial products, which are registered and then summed into the
// registered quotient, with a new dividend every cycle.
// ----------------------------------------------------------------------------
module ava_cdiv #(
  parameter int XW      = 34,
  parameter int DIVISOR = ava_pkg::DEF_WINDOW_DEPTH
) (
  input  logic          clk,
  input  logic [XW-1:0] dividend,
  output logic [XW-1:0] quotient
);

  localparam int SH   = XW + $clog2(DIVISOR);
  localparam int MW   = XW + 1;
  localparam int HW   = (XW + 1) / 2;
  localparam int HM   = (MW + 1) / 2;
  localparam int PW   = XW + MW;
  localparam int LL_W = HW + HM;
  localparam int LH_W = HW + MW - HM;
  localparam int HL_W = XW - HW + HM;
  localparam int HH_W = XW - HW + MW - HM;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam logic [HM-1:0]    RECIP_LO = RECIP[HM-1:0];
  localparam logic [MW-HM-1:0] RECIP_HI = RECIP[MW-1:HM];

  logic [HW-1:0]    x_lo;
  logic [XW-HW-1:0] x_hi;
  logic [LL_W-1:0]  pp_ll_r;
  logic [LH_W-1:0]  pp_lh_r;
  logic [HL_W-1:0]  pp_hl_r;
  logic [HH_W-1:0]  pp_hh_r;
  logic [PW-1:0]    prod;
  logic [XW-1:0]    quot_r;

  assign x_lo = dividend[HW-1:0];
  assign x_hi = dividend[XW-1:HW];

  always_ff @(posedge clk) begin
    pp_ll_r <= LL_W'(x_lo) * LL_W'(RECIP_LO);
    pp_lh_r <= LH_W'(x_lo) * LH_W'(RECIP_HI);
    pp_hl_r <= HL_W'(x_hi) * HL_W'(RECIP_LO);
    pp_hh_r <= HH_W'(x_hi) * HH_W'(RECIP_HI);
  end

  assign prod = PW'(pp_ll_r) + (PW'(pp_lh_r) << HM) + (PW'(pp_hl_r) << HW)
              + (PW'(pp_hh_r) << (HW + HM));

  always_ff @(posedge clk) begin
    quot_r <= XW'(prod >> SH);
  end

  assign quotient = quot_r;

endmodule

// ----- hw/rtl/averaged_voltage_autorange_unit.sv -----
// ----------------------------------------------------------------------------
// averaged_voltage_autorange_unit
// Moving average over a ring of converter samples, scaled to microvolts,
// with hysteresis range selection.
// ----------------------------------------------------------------------------
// The unit takes one sample transaction per clock while in_tready is high and
// returns one result transaction for each, in order. A sample enters the ring
// memory, whose single port reads the entry being replaced and writes the new
// sample in the same cycle; that port sets the rate of one transaction per
// cycle. A result is written to the output queue after the registered steps:
// the ring read, the window update, the two range products, the partial
// products and quotient of the division by the window depth through
// reciprocal multiplication, and the range decision. Results wait in an
// output queue sized to the pipeline, so input is taken while results are
// stalled until the queue is committed full. No clearing pass follows reset:
// entries of the ring count as zero until the write slot has wrapped once.
// ----------------------------------------------------------------------------
module averaged_voltage_autorange_unit #(
  parameter int WINDOW_DEPTH = ava_pkg::DEF_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = ava_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // adc_sample, zero padded
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,
  // over_voltage
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // voltage_uv, average_raw, zero padded
  output logic [39:0]                        out_tdata,
  // range_used_low, range_next_low
  output logic [1:0]                         out_tuser,
  input  logic                               cfg_we,
  input  logic [ava_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ava_pkg::CFG_W-1:0]          cfg_wdata
);

  import ava_pkg::*;

  localparam int SLOT_W     = $clog2(WINDOW_DEPTH);
  localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int PROD_W     = SUM_W + FACTOR_W;
  localparam int DIV_W      = (PROD_W > VOLT_W) ? PROD_W : VOLT_W + 1;
  localparam int DIV_STAGES = DIV_LAT;
  localparam int LAT        = DIV_STAGES + 4;
  localparam int FIFO_DEPTH = LAT + 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);
  localparam logic [VOLT_W-1:0] VOLT_MAX = '1;

  logic                   in_fire;
  logic                   out_fire;
  logic [SAMPLE_BITS-1:0] sample;

  logic [FACTOR_W-1:0] low_factor_r;
  logic [FACTOR_W-1:0] high_factor_r;
  logic [VOLT_W-1:0]   up_thr_r;
  logic [VOLT_W-1:0]   down_thr_r;

  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] ring_rd_r;
  logic [SLOT_W-1:0]      wr_slot_r;
  logic                   filled_r;

  logic                   s1_valid_r;
  logic                   s1_over_r;
  logic                   s1_old_ok_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic             s2_valid_r;
  logic             s2_over_r;

  logic              s3_valid_r;
  logic              s3_over_r;
  logic [PROD_W-1:0] p_low_r;
  logic [PROD_W-1:0] p_high_r;
  logic [SUM_W-1:0]  s3_sum_r;

  logic             dly_valid_r [DIV_STAGES];
  logic             dly_over_r  [DIV_STAGES];
  logic [DIV_W-1:0] q_low;
  logic [DIV_W-1:0] q_high;
  logic [DIV_W-1:0] q_avg;

  logic              fin_valid;
  logic              fin_over;
  logic [VOLT_W-1:0] volt_low;
  logic [VOLT_W-1:0] volt_high;
  logic [VOLT_W-1:0] volt_sel;
  logic              range_low_r;
  logic              range_low_nxt;
  result_t           fin_res;

  result_t          fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] fifo_wr_r;
  logic [PTR_W-1:0] fifo_rd_r;
  logic [OCC_W-1:0] fifo_cnt_r;
  logic [OCC_W-1:0] occ_r;
  result_t          head;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign sample   = in_tdata[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_factor_r  <= RST_LOW_FACTOR;
      high_factor_r <= RST_HIGH_FACTOR;
      up_thr_r      <= RST_UP_THR;
      down_thr_r    <= RST_DOWN_THR;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LOW_FACTOR:  low_factor_r  <= cfg_wdata[FACTOR_W-1:0];
        CFG_HIGH_FACTOR: high_factor_r <= cfg_wdata[FACTOR_W-1:0];
        CFG_UP_THR:      up_thr_r      <= cfg_wdata[VOLT_W-1:0];
        CFG_DOWN_THR:    down_thr_r    <= cfg_wdata[VOLT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The ring reads the replaced entry before writing the new sample.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring_rd_r          <= ring_mem[wr_slot_r];
      ring_mem[wr_slot_r] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r <= '0;
      filled_r  <= 1'b0;
    end else if (in_fire) begin
      if (wr_slot_r == SLOT_W'(WINDOW_DEPTH - 1)) begin
        wr_slot_r <= '0;
        filled_r  <= 1'b1;
      end else begin
        wr_slot_r <= wr_slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
    s1_over_r   <= in_tuser[0];
    s1_old_ok_r <= filled_r;
    s1_sample_r <= sample;
  end

  assign sum_nxt = sum_r - (s1_old_ok_r ? SUM_W'(ring_rd_r) : '0) + SUM_W'(s1_sample_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        sum_r <= sum_nxt;
      end
    end
    s2_over_r <= s1_over_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_over_r <= s2_over_r;
    s3_sum_r  <= sum_r;
    p_low_r   <= PROD_W'(sum_r) * PROD_W'(low_factor_r);
    p_high_r  <= PROD_W'(sum_r) * PROD_W'(high_factor_r);
  end

  ava_cdiv #(.XW(DIV_W), .DIVISOR(WINDOW_DEPTH)) u_div_low (
    .clk      (clk),
    .dividend (DIV_W'(p_low_r)),
    .quotient (q_low)
  );

  ava_cdiv #(.XW(DIV_W), .DIVISOR(WINDOW_DEPTH)) u_div_high (
    .clk      (clk),
    .dividend (DIV_W'(p_high_r)),
    .quotient (q_high)
  );

  ava_cdiv #(.XW(DIV_W), .DIVISOR(WINDOW_DEPTH)) u_div_avg (
    .clk      (clk),
    .dividend (DIV_W'(s3_sum_r)),
    .quotient (q_avg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        dly_valid_r[i] <= 1'b0;
      end
    end else begin
      dly_valid_r[0] <= s3_valid_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dly_valid_r[i] <= dly_valid_r[i-1];
      end
    end
    dly_over_r[0] <= s3_over_r;
    for (int i = 1; i < DIV_STAGES; i++) begin
      dly_over_r[i] <= dly_over_r[i-1];
    end
  end

  assign fin_valid = dly_valid_r[DIV_STAGES-1];
  assign fin_over  = dly_over_r[DIV_STAGES-1];
  assign volt_low  = (|q_low[DIV_W-1:VOLT_W])  ? VOLT_MAX : q_low[VOLT_W-1:0];
  assign volt_high = (|q_high[DIV_W-1:VOLT_W]) ? VOLT_MAX : q_high[VOLT_W-1:0];
  assign volt_sel  = range_low_r ? volt_low : volt_high;

  always_comb begin
    if (fin_over) begin
      range_low_nxt = 1'b0;
    end else if (range_low_r) begin
      range_low_nxt = !(volt_sel > up_thr_r);
    end else begin
      range_low_nxt = volt_sel < down_thr_r;
    end
    fin_res.range_next_low = range_low_nxt;
    fin_res.range_used_low = range_low_r;
    fin_res.average_raw    = q_avg[AVG_W-1:0];
    fin_res.voltage_uv     = volt_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r <= 1'b0;
    end else if (fin_valid) begin
      range_low_r <= range_low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid) begin
      fifo_mem[fifo_wr_r] <= fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wr_r  <= '0;
      fifo_rd_r  <= '0;
      fifo_cnt_r <= '0;
      occ_r      <= '0;
    end else begin
      if (fin_valid) begin
        fifo_wr_r <= (fifo_wr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : fifo_wr_r + 1'b1;
      end
      if (out_fire) begin
        fifo_rd_r <= (fifo_rd_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : fifo_rd_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + OCC_W'(fin_valid) - OCC_W'(out_fire);
      occ_r      <= occ_r + OCC_W'(in_fire) - OCC_W'(out_fire);
    end
  end

  assign head       = fifo_mem[fifo_rd_r];
  assign in_tready  = occ_r < OCC_W'(FIFO_DEPTH);
  assign out_tvalid = fifo_cnt_r != '0;
  assign out_tdata  = {4'b0000, head.average_raw, head.voltage_uv};
  assign out_tuser  = {head.range_next_low, head.range_used_low};

  a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(FIFO_DEPTH))
    else $error("Outstanding transaction count exceeds the output queue.");

  a_queue_within_occ : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= occ_r)
    else $error("Output queue holds more results than outstanding transactions.");

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid |-> fifo_cnt_r < OCC_W'(FIFO_DEPTH))
    else $error("Result written into a full output queue.");

  a_over_forces_high : assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && fin_over |=> !range_low_r)
    else $error("Over-voltage did not select the high range.");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the averaged voltage autorange unit. A table of
// directed transactions and register writes runs first, followed by random
// phases that each program all four registers and then stream samples
// around a chosen level. Untyped results are checked against a predictor of the
// window sum, scaling and hysteresis, while both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import ava_pkg::*;

  localparam int WINDOW      = 256;
  localparam int SMP_W       = 10;
  localparam int THR_MAX     = 67043805;
  localparam int NUM_PHASES  = 6;
  localparam int DIR_ROWS_N  = 28;

  typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t        kind;
    cfg_reg_t          sel;
    logic [CFG_W-1:0]  value;
    logic [SMP_W-1:0]  smp;
    logic              ovr;
    logic              typed;
    logic [VOLT_W-1:0] w_volt;
    logic [AVG_W-1:0]  w_avg;
    logic              w_used;
    logic              w_next;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd0,    1'b0, 1'b1, 26'd0,    10'd0, 1'b0, 1'b1},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd1023, 1'b0, 1'b1, 26'd3896, 10'd3, 1'b1, 1'b1},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd1023, 1'b1, 1'b1, 26'd7792, 10'd7, 1'b1, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd512,  1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_UP_THR,      26'd0,        10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd1,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_DOWN_THR,    26'd67043805, 10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd1023, 1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_LOW_FACTOR,  26'd0,        10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd700,  1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd1023, 1'b1, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_HIGH_FACTOR, 26'd0,        10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_DOWN_THR,    26'd0,        10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd300,  1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd0,    1'b1, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_LOW_FACTOR,  26'h3FFFFFF,  10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_HIGH_FACTOR, 26'h2AAFFFF,  10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_UP_THR,      26'd67043805, 10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_DOWN_THR,    26'd67043805, 10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd1023, 1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd1023, 1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd512,  1'b1, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_LOW_FACTOR,  26'd975,      10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_HIGH_FACTOR, 26'd4882,     10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_UP_THR,      26'd3000000,  10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_WRITE,  CFG_DOWN_THR,    26'd2500000,  10'd0,    1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd341,  1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0},
    '{STEP_SAMPLE, CFG_LOW_FACTOR,  26'd0,        10'd682,  1'b0, 1'b0, 26'd0,    10'd0, 1'b0, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;
  logic [0:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;
  logic [1:0]        out_tuser;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  logic [SMP_W-1:0]    m_ring [WINDOW];
  logic [7:0]          m_slot;
  logic [17:0]         m_sum;
  logic                m_low;
  logic [FACTOR_W-1:0] m_low_factor;
  logic [FACTOR_W-1:0] m_high_factor;
  logic [VOLT_W-1:0]   m_up_uv;
  logic [VOLT_W-1:0]   m_down_uv;

  result_t pending_readings [$];
  int      samples_sent = 0;
  int      directed_sent = 0;
  int      readings_checked = 0;
  int      range_flips = 0;
  int      reg_writes = 0;
  int      mismatches = 0;
  int      burst_left = 1;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [5:0]  stall_count = '0;

  averaged_voltage_autorange_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic result_t predict_reading(input logic [SMP_W-1:0] smp, input logic ovr);
    logic [63:0] scaled;
    logic        used;
    result_t     r;
    m_sum = m_sum - 18'(m_ring[m_slot]) + 18'(smp);
    m_ring[m_slot] = smp;
    m_slot = m_slot + 8'd1;
    used = m_low;
    scaled = (64'(m_sum) * 64'(used ? m_low_factor : m_high_factor)) / 64'(WINDOW);
    if (scaled > 64'h3FFFFFF) scaled = 64'h3FFFFFF;
    if (ovr) begin
      m_low = 1'b0;
    end else if (used) begin
      if (scaled > 64'(m_up_uv)) m_low = 1'b0;
    end else if (scaled < 64'(m_down_uv)) begin
      m_low = 1'b1;
    end
    r.voltage_uv     = scaled[VOLT_W-1:0];
    r.average_raw    = m_sum[17:8];
    r.range_used_low = used;
    r.range_next_low = m_low;
    return r;
  endfunction

  function automatic logic [FACTOR_W-1:0] pick_factor(input logic [FACTOR_W-1:0] nominal);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return nominal;
      default: return FACTOR_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    case (sel)
      CFG_LOW_FACTOR:  m_low_factor  = value[FACTOR_W-1:0];
      CFG_HIGH_FACTOR: m_high_factor = value[FACTOR_W-1:0];
      CFG_UP_THR:      m_up_uv       = value[VOLT_W-1:0];
      CFG_DOWN_THR:    m_down_uv     = value[VOLT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic put_sample(input logic [SMP_W-1:0] smp, input logic ovr, input logic typed,
                            input result_t typed_reading);
    result_t predicted;
    int      gap;
    cfg_we    <= 1'b0;
    in_tvalid <= 1'b1;
    in_tdata  <= 16'(smp);
    in_tuser  <= ovr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_reading(smp, ovr);
    pending_readings.push_back(typed ? typed_reading : predicted);
    samples_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    stall_count <= stall_count + 6'd1;
    if (stall_count == '0) begin
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    out_tready <= stall_pattern[stall_count[3:0]];
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: result with nothing pending, data %h user %b", $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata[VOLT_W-1:0] !== want.voltage_uv) begin
          $display("%0t: voltage_uv expected %0d actual %0d", $time, want.voltage_uv,
                   out_tdata[VOLT_W-1:0]);
          mismatches++;
        end
        if (out_tdata[VOLT_W +: AVG_W] !== want.average_raw) begin
          $display("%0t: average_raw expected %0d actual %0d", $time, want.average_raw,
                   out_tdata[VOLT_W +: AVG_W]);
          mismatches++;
        end
        if (out_tuser[0] !== want.range_used_low) begin
          $display("%0t: range_used_low expected %b actual %b", $time, want.range_used_low,
                   out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[1] !== want.range_next_low) begin
          $display("%0t: range_next_low expected %b actual %b", $time, want.range_next_low,
                   out_tuser[1]);
          mismatches++;
        end
        if (want.range_used_low != want.range_next_low) range_flips++;
        readings_checked++;
      end
    end
  end

  initial begin
    int              level;
    int              spread;
    int              ov_odds;
    int              n_items;
    int              v;
    logic [FACTOR_W-1:0] lf;
    logic [FACTOR_W-1:0] hf;
    longint          up;
    longint          dn;
    dir_row_t        row;

    for (int i = 0; i < WINDOW; i++) m_ring[i] = '0;
    m_slot        = '0;
    m_sum         = '0;
    m_low         = 1'b0;
    m_low_factor  = RST_LOW_FACTOR;
    m_high_factor = RST_HIGH_FACTOR;
    m_up_uv       = RST_UP_THR;
    m_down_uv     = RST_DOWN_THR;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == STEP_WRITE) begin
        write_reg(row.sel, row.value);
      end else begin
        put_sample(row.smp, row.ovr, row.typed,
                   result_t'({row.w_next, row.w_used, row.w_avg, row.w_volt}));
      end
    end
    directed_sent = samples_sent;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        // Full-scale window with the largest factors gives the largest voltage.
        lf = '1;
        hf = '1;
        level = 1023;
        spread = 0;
        n_items = 300;
      end else begin
        lf = pick_factor(RST_LOW_FACTOR);
        hf = pick_factor(RST_HIGH_FACTOR);
        level = (p == 1) ? 0 : $urandom_range(0, 1023);
        spread = $urandom_range(0, 300);
        n_items = 190;
      end
      up = (longint'(level) * lf * $urandom_range(50, 150)) / 100;
      dn = (longint'(level) * hf * $urandom_range(50, 150)) / 100;
      if (up > THR_MAX) up = THR_MAX;
      if (dn > THR_MAX) dn = THR_MAX;
      ov_odds = $urandom_range(8, 40);
      write_reg(CFG_LOW_FACTOR, CFG_W'(lf));
      write_reg(CFG_HIGH_FACTOR, CFG_W'(hf));
      write_reg(CFG_UP_THR, CFG_W'(up));
      write_reg(CFG_DOWN_THR, CFG_W'(dn));
      for (int k = 0; k < n_items; k++) begin
        if (p != 0 && $urandom_range(0, 15) == 0) begin
          v = $urandom_range(0, 1023);
        end else begin
          v = level + $urandom_range(0, 2 * spread) - spread;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
        end
        put_sample(SMP_W'(v), ($urandom_range(1, ov_odds) == 1), 1'b0, '0);
      end
    end

    cfg_we    <= 1'b0;
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d sample transactions (%0d directed) across %0d register writes.",
             samples_sent, directed_sent, reg_writes);
    $display("Checked %0d results, %0d of them with a range change, %0d mismatches.",
             readings_checked, range_flips, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
